// ===== src/nsc_pkg.sv =====
// Package for the non-overlapping substring counter.
// Holds the register map, bus widths and the configuration struct.
// No dependencies; compile first.
package nsc_pkg;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned OFFSET_W   = 32;
	localparam int unsigned SKIP_W     = 4;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2,
		REG_BLOCK_LIMIT    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [127:0]         pattern;   // byte 0 in bits 7:0
		logic [LEN_W-1:0]     length;
		logic [OFFSET_W-1:0]  limit;
	} cfg_t;

endpackage

// ===== src/nsc_cfg.sv =====
// Configuration registers of the substring counter behind an APB-style port.
// Depends on nsc_pkg. Registers sit at byte addresses 0, 8, 16 and 24.
module nsc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [nsc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [nsc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [nsc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output nsc_pkg::cfg_t                   cfg
);
	import nsc_pkg::*;

	logic [63:0]          pat_low_q;
	logic [63:0]          pat_high_q;
	logic [LEN_W-1:0]     length_q;
	logic [OFFSET_W-1:0]  limit_q;
	logic                 wr_en;
	reg_idx_t             idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			length_q   <= LEN_W'(1);
			limit_q    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PATTERN_LOW:    pat_low_q  <= pwdata;
				REG_PATTERN_HIGH:   pat_high_q <= pwdata;
				REG_PATTERN_LENGTH: length_q   <= pwdata[LEN_W-1:0];
				REG_BLOCK_LIMIT:    limit_q    <= pwdata[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PATTERN_LOW:    prdata = pat_low_q;
			REG_PATTERN_HIGH:   prdata = pat_high_q;
			REG_PATTERN_LENGTH: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, length_q};
			REG_BLOCK_LIMIT:    prdata = {{(APB_DATA_W-OFFSET_W){1'b0}}, limit_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.pattern = {pat_high_q, pat_low_q};
	assign cfg.length  = length_q;
	assign cfg.limit   = limit_q;

endmodule

// ===== src/nsc_match.sv =====
// Match core: byte history window, parallel pattern compare and block state.
// Depends on nsc_pkg. Processes one byte per strobe; clears on the last byte.
module nsc_match #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [7:0]                    text_byte,
	input  logic                          block_end,
	input  nsc_pkg::cfg_t                 cfg,
	output logic [nsc_pkg::COUNT_W-1:0]   count_next
);
	import nsc_pkg::*;

	localparam int unsigned WIN_D = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
	localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	logic [7:0]           win_q [WIN_D];
	logic [OFFSET_W-1:0]  offset_q;
	logic [SKIP_W-1:0]    skip_q;
	logic [COUNT_W-1:0]   found_q;
	logic                 ended_q;

	logic [7:0]           hist [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0]     len_eff;
	logic [LEN_W-1:0]     len_m1;
	logic [LEN_W-1:0]     back;
	logic                 all_eq;
	logic                 long_enough;
	logic                 take;
	logic                 hit;
	logic [OFFSET_W-1:0]  start;
	logic                 counted;
	logic [SKIP_W-1:0]    skip_next;

	always_comb begin
		len_eff = (cfg.length > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES)
		                                                   : cfg.length;
		len_m1  = len_eff - LEN_W'(1);

		// hist[0] is the current byte, hist[j] lies j bytes back
		hist[0] = text_byte;
		for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
			hist[j] = win_q[j-1];
		end

		// pattern byte k lines up with the byte len-1-k positions back
		all_eq = 1'b1;
		back   = '0;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			back = len_m1 - LEN_W'(k);
			if (LEN_W'(k) < len_eff &&
			    hist[back[IDX_W-1:0]] != cfg.pattern[8*k +: 8]) begin
				all_eq = 1'b0;
			end
		end

		long_enough = ({1'b0, offset_q} + (OFFSET_W+1)'(1)) >= (OFFSET_W+1)'(len_eff);
		take        = step && !ended_q && (text_byte != 8'd0);
		hit         = take && (skip_q == '0) && (len_eff != '0) && long_enough && all_eq;
		start       = offset_q - OFFSET_W'(len_m1);
		counted     = hit && (start < cfg.limit) && (found_q != {COUNT_W{1'b1}});
		count_next  = found_q + COUNT_W'(counted);

		skip_next = skip_q;
		if (take) begin
			if (skip_q != '0) begin
				skip_next = skip_q - SKIP_W'(1);
			end else if (hit) begin
				skip_next = len_m1[SKIP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < WIN_D; j++) win_q[j] <= '0;
			offset_q <= '0;
			skip_q   <= '0;
			found_q  <= '0;
			ended_q  <= 1'b0;
		end else if (step) begin
			if (block_end) begin
				for (int j = 0; j < WIN_D; j++) win_q[j] <= '0;
				offset_q <= '0;
				skip_q   <= '0;
				found_q  <= '0;
				ended_q  <= 1'b0;
			end else begin
				if (take) begin
					win_q[0] <= text_byte;
					for (int j = 1; j < WIN_D; j++) win_q[j] <= win_q[j-1];
					if (offset_q != {OFFSET_W{1'b1}}) offset_q <= offset_q + OFFSET_W'(1);
				end
				skip_q  <= skip_next;
				found_q <= count_next;
				if (!ended_q && text_byte == 8'd0) ended_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/nonoverlap_substring_counter.sv =====
// Non-overlapping substring counter, top level.
// An accepted byte is registered in the s1 stage and then processed by the match core;
// a block's last byte also loads the count into the output register, but waits
// while that register is full. One byte per cycle otherwise, via the parallel compare.
// Reset (arst_n low, asynchronous) clears all block state and sets pattern_length to 1.
module nonoverlap_substring_counter #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [nsc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [nsc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [nsc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	// text stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] text_byte
	input  logic                            s_tlast,   // block_end
	// count stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [nsc_pkg::COUNT_W-1:0]     m_tdata    // [31:0] match_count
);
	import nsc_pkg::*;

	cfg_t                cfg;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                advance;
	logic [COUNT_W-1:0]  count_next;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  count_q;

	nsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// a last byte waits only while the output register holds an untaken count
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	nsc_match #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.text_byte  (byte_s1),
		.block_end  (last_s1),
		.cfg        (cfg),
		.count_next (count_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			count_q <= count_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = count_q;

endmodule
